/* src/mslcg_pkg.sv */
// ============================================================================
// mslcg_pkg
// Shared types and constants for the scaled minimal-standard LCG.
// ============================================================================
`default_nettype none

package mslcg_pkg;

    localparam int unsigned SEED_W     = 31;
    localparam int unsigned MULT_W     = 15;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_MAX = 31'h7FFF_FFFE;
    localparam logic [SEED_W-1:0] SEED_ONE = 31'd1;

    localparam logic [DATA_W-1:0] UPPER_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] LOWER_RESET = 32'h0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 8'd1;

    localparam logic REQ_NEXT = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic              is_load;
        logic              rejected;
        logic [SEED_W-1:0] seed;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LO,
        BK_HI,
        BK_FIN
    } back_state_t;

endpackage

`default_nettype wire

/* src/mslcg_front.sv */
// ============================================================================
// mslcg_front
// Accepts requests, advances or loads the seed and queues the item.
// ============================================================================
`default_nettype none

module mslcg_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         req_type,
    input  wire logic [31:0]                  load_seed,
    output logic                              q_push,
    output mslcg_pkg::item_t                  q_data,
    input  wire logic                         q_full
);

    logic [mslcg_pkg::SEED_W-1:0] seed_reg;
    logic [mslcg_pkg::SEED_W-1:0] seed_next;
    logic [45:0]                  prod;
    logic [31:0]                  fold;
    logic [31:0]                  fold_red;
    logic [mslcg_pkg::SEED_W-1:0] lcg_seed;
    logic                         load_ok;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // seed * 16807 mod 2^31-1 via Mersenne fold
    assign prod     = 46'(mslcg_pkg::LCG_MULT) * 46'(seed_reg);
    assign fold     = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
    assign fold_red = (fold >= {1'b0, mslcg_pkg::LCG_MOD})
                      ? (fold - {1'b0, mslcg_pkg::LCG_MOD}) : fold;
    assign lcg_seed = fold_red[mslcg_pkg::SEED_W-1:0];

    assign load_ok  = (load_seed != 32'd0) && (load_seed <= {1'b0, mslcg_pkg::SEED_MAX});

    always_comb
    begin
        q_data.is_load  = (req_type == mslcg_pkg::REQ_LOAD);
        q_data.rejected = 1'b0;
        if (req_type == mslcg_pkg::REQ_LOAD)
        begin
            if (load_ok)
            begin
                seed_next = load_seed[mslcg_pkg::SEED_W-1:0];
            end
            else
            begin
                seed_next       = mslcg_pkg::SEED_ONE;
                q_data.rejected = 1'b1;
            end
        end
        else
        begin
            seed_next = lcg_seed;
        end
        q_data.seed = seed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mslcg_pkg::SEED_ONE;
        end
        else if (q_push)
        begin
            seed_reg <= seed_next;
        end
    end

endmodule

`default_nettype wire

/* src/mslcg_fifo.sv */
// ============================================================================
// mslcg_fifo
// Two-entry queue between the seed front end and the scaling back end.
// ============================================================================
`default_nettype none

module mslcg_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mslcg_pkg::item_t  wr_data,
    output logic                   full,
    input  wire logic              pop,
    output mslcg_pkg::item_t       rd_data,
    output logic                   empty
);

    mslcg_pkg::item_t mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/mslcg_back.sv */
// ============================================================================
// mslcg_back
// Scales the seed into the configured range and holds the result register.
// ============================================================================
`default_nettype none

module mslcg_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire mslcg_pkg::item_t             q_data,
    output logic                              q_pop,
    input  wire logic [31:0]                  upper_limit,
    input  wire logic [31:0]                  lower_limit,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [31:0]                       scaled_value,
    output logic [mslcg_pkg::SEED_W-1:0]      raw_seed,
    output logic                              seed_rejected
);

    mslcg_pkg::back_state_t state_reg;
    mslcg_pkg::back_state_t state_next;

    mslcg_pkg::item_t item_reg;
    logic [32:0]      mag_reg;
    logic             neg_reg;
    logic [63:0]      acc_reg;
    logic             out_valid_reg;
    logic [31:0]      scaled_reg;
    logic [30:0]      raw_seed_reg;
    logic             rejected_reg;

    logic [32:0]      diff;
    logic [32:0]      mag;
    logic [46:0]      pp_lo;
    logic [47:0]      pp_hi;
    logic [63:0]      bias;
    logic [32:0]      qmag;
    logic [34:0]      lower_ext;
    logic [34:0]      sum;
    logic [31:0]      sat;
    logic             out_free;
    logic             load_out;

    assign diff  = {upper_limit[31], upper_limit} - {lower_limit[31], lower_limit};
    assign mag   = diff[32] ? (~diff + 33'd1) : diff;

    assign pp_lo = 47'(mag_reg[15:0]) * 47'(item_reg.seed);
    assign pp_hi = 48'(mag_reg[32:16]) * 48'(item_reg.seed);
    // rounding toward minus infinity on a negative range
    assign bias  = neg_reg ? 64'h0000_0000_7FFF_FFFF : 64'd0;

    assign qmag      = acc_reg[63:31];
    assign lower_ext = {{3{lower_limit[31]}}, lower_limit};
    assign sum       = neg_reg ? (lower_ext - {2'b00, qmag}) : (lower_ext + {2'b00, qmag});

    always_comb
    begin
        if (!sum[34] && (sum[33:31] != 3'b000))
        begin
            sat = 32'h7FFF_FFFF;
        end
        else if (sum[34] && (sum[33:31] != 3'b111))
        begin
            sat = 32'h8000_0000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            mslcg_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = mslcg_pkg::BK_LO;
                end
            end
            mslcg_pkg::BK_LO:
            begin
                state_next = mslcg_pkg::BK_HI;
            end
            mslcg_pkg::BK_HI:
            begin
                state_next = mslcg_pkg::BK_FIN;
            end
            mslcg_pkg::BK_FIN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = mslcg_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mslcg_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mslcg_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
            mag_reg  <= mag;
            neg_reg  <= diff[32];
        end
        if (state_reg == mslcg_pkg::BK_LO)
        begin
            acc_reg <= 64'(pp_lo) + bias;
        end
        else if (state_reg == mslcg_pkg::BK_HI)
        begin
            acc_reg <= acc_reg + {pp_hi, 16'd0};
        end
        if (load_out)
        begin
            scaled_reg   <= item_reg.is_load ? 32'd0 : sat;
            raw_seed_reg <= item_reg.seed;
            rejected_reg <= item_reg.rejected;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scaled_value  = scaled_reg;
    assign raw_seed      = raw_seed_reg;
    assign seed_rejected = rejected_reg;

endmodule

`default_nettype wire

/* src/minimal_standard_lcg_scaled_unit.sv */
// ============================================================================
// minimal_standard_lcg_scaled_unit
// Minimal-standard Lehmer generator (x16807 mod 2^31-1) with Q16.16 scaling.
// ============================================================================
// Input stream: tuser[0] = 0 asks for the next number, 1 loads tdata as seed.
// Seeds outside 1..2^31-2 load 1 and set the rejected flag in m_axis_tuser.
// Output stream: one item per request; tdata = scaled value (Q16.16, zero on
// a load) and the 31-bit seed after the request, tuser = seed rejected.
// The front end updates the seed in the accept cycle (one 31x15 multiply and
// a Mersenne fold) and pushes into a two-entry queue.
// The back end splits the 33x31 range product into two halves, summed in the
// BK_LO and BK_HI states, then rounds, offsets and saturates into the output
// register in BK_FIN. It takes a new item from the queue only in BK_IDLE,
// after the previous item has been loaded into the output register.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready drops after two more items.
// Reset sets the seed to 1, upper limit to 1.0 and lower limit to 0.
// Config writes (index 0 upper, 1 lower) are always ready; others are ignored.
// ============================================================================
`default_nettype none

module minimal_standard_lcg_scaled_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] load_seed
    input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] scaled_value, [62:32] raw_seed
    output logic [0:0]       m_axis_tuser,   // [0] seed_rejected
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0]      upper_reg;
    logic [31:0]      lower_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    mslcg_pkg::item_t q_wr;
    mslcg_pkg::item_t q_rd;
    logic [31:0]      scaled_value;
    logic [30:0]      raw_seed;
    logic             seed_rejected;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= mslcg_pkg::UPPER_RESET;
            lower_reg <= mslcg_pkg::LOWER_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mslcg_pkg::CFG_UPPER: upper_reg <= cfg_data;
                mslcg_pkg::CFG_LOWER: lower_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mslcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tuser[0]),
        .load_seed  (s_axis_tdata),
        .q_push     (q_push),
        .q_data     (q_wr),
        .q_full     (q_full)
    );

    mslcg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    mslcg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rd),
        .q_pop         (q_pop),
        .upper_limit   (upper_reg),
        .lower_limit   (lower_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .scaled_value  (scaled_value),
        .raw_seed      (raw_seed),
        .seed_rejected (seed_rejected)
    );

    assign m_axis_tdata = {1'b0, raw_seed, scaled_value};
    assign m_axis_tuser = seed_rejected;

endmodule

`default_nettype wire
